[rtl/core/ffa_pkg.sv]
// Shared types, codes and default constants of the first-fit block allocator.
`default_nettype none
package ffa_pkg;

   // Default sizes of the heap.
   localparam int NUM_SLOTS_DEF   = 64;
   localparam int BLOCK_BYTES_DEF = 512;
   localparam int DESC_BYTES_DEF  = 16;

   // A free block below the last request that started a coalescing walk plus this slack keeps absorbing neighbors.
   localparam int MERGE_SLACK = 64;

   // Command codes.
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_ALIGNED = 2'd1;
   localparam logic [1:0] CMD_FREE    = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_BAD_ALIGN = 2'd2;
   localparam logic [1:0] ST_OUTSIDE   = 2'd3;

   // Configuration register indexes.
   localparam logic REG_HEAP_BASE   = 1'b0;
   localparam logic REG_BLOCK_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] request_size;
      logic [6:0]  alignment;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_address;
      logic        is_allocated;
   } rsp_type;

   // Update requests from the sequencer to the slot table.
   typedef struct packed {
      logic rebuild;   // every slot back to a free single block
      logic wr_size;   // store a merged size at the write index
      logic clr_head;  // the looked-up slot joins the block before it
      logic set_free;  // the looked-up block becomes free
      logic clr_free;  // the looked-up block becomes allocated
   } slot_ctl_type;

   // Only the powers of two from 4 to 64 are legal alignments.
   function automatic logic align_ok(input logic [6:0] a);
      return (a == 7'd4) || (a == 7'd8) || (a == 7'd16) || (a == 7'd32) || (a == 7'd64);
   endfunction

endpackage
`default_nettype wire

[rtl/core/ffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

[rtl/core/ffa_slots.sv]
// Slot table: head, free and merged flags per slot plus the RAM of merged block sizes.
`default_nettype none
module ffa_slots #(
   parameter int NUM_SLOTS   = ffa_pkg::NUM_SLOTS_DEF,
   parameter int BLOCK_BYTES = ffa_pkg::BLOCK_BYTES_DEF,
   parameter int IW          = $clog2(NUM_SLOTS),
   parameter int SW          = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ffa_pkg::slot_ctl_type ctl,
   input  wire logic [IW-1:0]        look_idx,
   input  wire logic [IW-1:0]        wr_idx,
   input  wire logic [SW-1:0]        wr_data,
   output logic                      look_head,
   output logic                      look_free,
   output logic [SW-1:0]             size_q
);

   localparam int DEPTH = 1 << IW;

   logic [DEPTH-1:0] head_ff, head_in;
   logic [DEPTH-1:0] free_ff, free_in;
   logic [DEPTH-1:0] merged_ff, merged_in;
   logic             merged_q_ff;
   logic [SW-1:0]    ram_q;

   assign look_head = head_ff[look_idx];
   assign look_free = free_ff[look_idx];

   // A slot that never absorbed a neighbor holds the plain block size.
   assign size_q = merged_q_ff ? ram_q : SW'(BLOCK_BYTES);

   // Flag updates.
   always_comb begin
      head_in   = head_ff;
      free_in   = free_ff;
      merged_in = merged_ff;
      if (ctl.rebuild) begin
         head_in   = '1;
         free_in   = '1;
         merged_in = '0;
      end else begin
         if (ctl.clr_head) head_in[look_idx] = 1'b0;
         if (ctl.set_free) free_in[look_idx] = 1'b1;
         if (ctl.clr_free) free_in[look_idx] = 1'b0;
         if (ctl.wr_size)  merged_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '1;
         free_ff   <= '1;
         merged_ff <= '0;
      end else begin
         head_ff   <= head_in;
         free_ff   <= free_in;
         merged_ff <= merged_in;
      end
      merged_q_ff <= merged_ff[look_idx];
   end

   // Sizes of merged blocks.
   ffa_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_size_ram (
      .clock (clock),
      .we    (ctl.wr_size),
      .waddr (wr_idx),
      .wdata (wr_data),
      .raddr (look_idx),
      .rdata (ram_q)
   );

endmodule
`default_nettype wire

[rtl/core/ffa_ctrl.sv]
// Sequencer: walks the slot table one slot per step for coalescing, allocation and lookup.
`default_nettype none
module ffa_ctrl #(
   parameter int NUM_SLOTS   = ffa_pkg::NUM_SLOTS_DEF,
   parameter int BLOCK_BYTES = ffa_pkg::BLOCK_BYTES_DEF,
   parameter int DESC_BYTES  = ffa_pkg::DESC_BYTES_DEF,
   parameter int IW          = $clog2(NUM_SLOTS),
   parameter int SW          = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cfg_wr,
   input  wire logic [31:0]           heap_base,
   input  wire logic [IW:0]           n_active,
   input  wire logic                  start,
   input  wire ffa_pkg::req_type      req_payload,
   output logic                       busy,
   output logic                       rsp_valid,
   output ffa_pkg::rsp_type           rsp_payload,
   output ffa_pkg::slot_ctl_type      ctl,
   output logic [IW-1:0]              look_idx,
   output logic [IW-1:0]              wr_idx,
   output logic [SW-1:0]              wr_data,
   input  wire logic                  look_head,
   input  wire logic                  look_free,
   input  wire logic [SW-1:0]         size_q
);

   localparam int STRIDE = DESC_BYTES + BLOCK_BYTES;
   localparam int CW     = ((SW > 17) ? SW : 17) + 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CO_SCAN = 4'd1;
   localparam logic [3:0] S_CO_EVP  = 4'd2;
   localparam logic [3:0] S_CO_EVQ  = 4'd3;
   localparam logic [3:0] S_CO_END  = 4'd4;
   localparam logic [3:0] S_A_CHK   = 4'd5;
   localparam logic [3:0] S_A_SCAN  = 4'd6;
   localparam logic [3:0] S_A_EV    = 4'd7;
   localparam logic [3:0] S_F_SCAN  = 4'd8;
   localparam logic [3:0] S_F_ACT   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [15:0]   rq_ff, rq_in;
   logic [6:0]    al_ff, al_in;
   logic [31:0]   off_ff, off_in;
   logic [IW:0]   j_ff, j_in;
   logic [IW:0]   p_ff, p_in;
   logic [IW:0]   h_ff, h_in;
   logic          scanq_ff, scanq_in;
   logic          fresh_ff, fresh_in;
   logic [SW-1:0] sizep_ff, sizep_in;
   logic [SW-1:0] lb_ff, lb_in;
   logic [15:0]   lr_ff, lr_in;
   logic [31:0]   paddr_ff, paddr_in;
   logic [31:0]   sstart_ff, sstart_in;
   logic [31:0]   hstart_ff, hstart_in;
   logic          valid_ff, valid_in;
   ffa_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0] sz_p;
   logic [SW-1:0] newsz;
   logic [6:0]    amask;
   logic [6:0]    alow;
   logic [6:0]    shift;
   logic          j_end;
   logic [31:0]   cur_hstart;
   logic [32:0]   slot_end;

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;
   assign wr_idx      = p_ff[IW-1:0];
   assign wr_data     = newsz;

   assign j_end      = (j_ff >= n_active);
   assign sz_p       = fresh_ff ? size_q : sizep_ff;
   assign newsz      = sizep_ff + size_q + SW'(DESC_BYTES);
   assign amask      = (cmd_ff == ffa_pkg::CMD_ALIGNED) ? (al_ff - 7'd1) : 7'd0;
   assign alow       = paddr_ff[6:0] & amask;
   assign shift      = (alow == 7'd0) ? 7'd0 : (al_ff - alow);
   assign cur_hstart = look_head ? sstart_ff : hstart_ff;
   assign slot_end   = {1'b0, sstart_ff} + 33'(STRIDE);

   // Table index that the current step looks at.
   always_comb begin
      case (state_ff)
         S_CO_EVP: look_idx = p_ff[IW-1:0];
         S_F_ACT:  look_idx = h_ff[IW-1:0];
         default:  look_idx = j_ff[IW-1:0];
      endcase
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      rq_in     = rq_ff;
      al_in     = al_ff;
      off_in    = off_ff;
      j_in      = j_ff;
      p_in      = p_ff;
      h_in      = h_ff;
      scanq_in  = scanq_ff;
      fresh_in  = fresh_ff;
      sizep_in  = sizep_ff;
      lb_in     = lb_ff;
      lr_in     = lr_ff;
      paddr_in  = paddr_ff;
      sstart_in = sstart_ff;
      hstart_in = hstart_ff;
      valid_in  = 1'b0;
      rsp_in    = rsp_ff;
      ctl       = '0;
      ctl.rebuild = cfg_wr;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_payload.cmd;
               rq_in     = req_payload.request_size;
               al_in     = req_payload.alignment;
               off_in    = req_payload.address - heap_base;
               j_in      = '0;
               p_in      = '0;
               h_in      = '0;
               scanq_in  = 1'b0;
               sstart_in = '0;
               hstart_in = '0;
               rsp_in    = '0;
               if (req_payload.cmd == ffa_pkg::CMD_FREE ||
                   req_payload.cmd == ffa_pkg::CMD_QUERY) begin
                  state_in = S_F_SCAN;
               end else if (CW'(req_payload.request_size) > CW'(lb_ff)) begin
                  lr_in    = req_payload.request_size;
                  state_in = S_CO_SCAN;
               end else begin
                  state_in = S_A_CHK;
               end
            end
         end

         // Find the next head from j; it becomes p or q.
         S_CO_SCAN: begin
            if (j_end) begin
               state_in = S_CO_END;
            end else if (look_head) begin
               fresh_in = 1'b1;
               if (scanq_ff) begin
                  state_in = S_CO_EVQ;
               end else begin
                  p_in     = j_ff;
                  state_in = S_CO_EVP;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end

         // Does head p still want to grow? The search resumes past the last slot seen.
         S_CO_EVP: begin
            sizep_in = sz_p;
            j_in     = j_ff + 1'b1;
            scanq_in = look_free &&
                       (CW'(sz_p) < CW'(lr_ff) + CW'(ffa_pkg::MERGE_SLACK));
            state_in = S_CO_SCAN;
         end

         // Absorb head q into p when it is free, else continue after q.
         S_CO_EVQ: begin
            if (look_free) begin
               ctl.wr_size  = 1'b1;
               ctl.clr_head = 1'b1;
               sizep_in     = newsz;
               if (newsz > lb_ff) lb_in = newsz;
               fresh_in     = 1'b0;
               state_in     = S_CO_EVP;
            end else begin
               j_in     = j_ff + 1'b1;
               scanq_in = 1'b0;
               state_in = S_CO_SCAN;
            end
         end

         S_CO_END: begin
            if (CW'(rq_ff) > CW'(lb_ff)) begin
               rsp_in.status = ffa_pkg::ST_NO_FIT;
               valid_in      = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_A_CHK;
            end
         end

         S_A_CHK: begin
            j_in     = '0;
            paddr_in = heap_base + 32'(DESC_BYTES);
            if (cmd_ff == ffa_pkg::CMD_ALIGNED && !ffa_pkg::align_ok(al_ff)) begin
               rsp_in.status = ffa_pkg::ST_BAD_ALIGN;
               valid_in      = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_A_SCAN;
            end
         end

         // Skip to the next free head; its size is read meanwhile.
         S_A_SCAN: begin
            if (j_end) begin
               rsp_in.status = ffa_pkg::ST_NO_FIT;
               valid_in      = 1'b1;
               state_in      = S_IDLE;
            end else if (look_head && look_free) begin
               state_in = S_A_EV;
            end else begin
               j_in     = j_ff + 1'b1;
               paddr_in = paddr_ff + 32'(STRIDE);
            end
         end

         // Fit check with the alignment shift.
         S_A_EV: begin
            if (CW'(size_q) >= CW'(rq_ff) + CW'(shift)) begin
               ctl.clr_free         = 1'b1;
               rsp_in.status        = ffa_pkg::ST_OK;
               rsp_in.block_address = paddr_ff + 32'(shift);
               valid_in             = 1'b1;
               state_in             = S_IDLE;
            end else begin
               j_in     = j_ff + 1'b1;
               paddr_in = paddr_ff + 32'(STRIDE);
               state_in = S_A_SCAN;
            end
         end

         // Walk up to the slot that holds the offset, tracking the last head.
         S_F_SCAN: begin
            if (j_end) begin
               rsp_in.status = ffa_pkg::ST_OUTSIDE;
               valid_in      = 1'b1;
               state_in      = S_IDLE;
            end else begin
               if (look_head) begin
                  h_in      = j_ff;
                  hstart_in = sstart_ff;
               end
               if ({1'b0, off_ff} < slot_end) begin
                  if ({1'b0, off_ff} < {1'b0, cur_hstart} + 33'(DESC_BYTES)) begin
                     rsp_in.status = ffa_pkg::ST_OUTSIDE;
                     valid_in      = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_F_ACT;
                  end
               end else begin
                  j_in      = j_ff + 1'b1;
                  sstart_in = slot_end[31:0];
               end
            end
         end

         S_F_ACT: begin
            rsp_in.status = ffa_pkg::ST_OK;
            if (cmd_ff == ffa_pkg::CMD_FREE) begin
               ctl.set_free = 1'b1;
            end else begin
               rsp_in.is_allocated = !look_free;
            end
            valid_in = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write rebuilds the heap.
      if (cfg_wr) begin
         lb_in = SW'(BLOCK_BYTES);
         lr_in = 16'(BLOCK_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         lb_ff    <= SW'(BLOCK_BYTES);
         lr_ff    <= 16'(BLOCK_BYTES);
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         lb_ff    <= lb_in;
         lr_ff    <= lr_in;
      end
      cmd_ff    <= cmd_in;
      rq_ff     <= rq_in;
      al_ff     <= al_in;
      off_ff    <= off_in;
      j_ff      <= j_in;
      p_ff      <= p_in;
      h_ff      <= h_in;
      scanq_ff  <= scanq_in;
      fresh_ff  <= fresh_in;
      sizep_ff  <= sizep_in;
      paddr_ff  <= paddr_in;
      sstart_ff <= sstart_in;
      hstart_ff <= hstart_in;
      rsp_ff    <= rsp_in;
   end

endmodule
`default_nettype wire

[rtl/core/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: register port, sequencer and slot table.
`default_nettype none
// One item is taken when start is high and busy is low; busy then stays high until the
// result, which appears for exactly one cycle with rsp_valid, so the receiver must take it
// at once. Every step visits one slot of the table, and a request larger than the largest
// block size recorded since the last rebuild first runs a coalescing walk over the active
// slots. Register writes rebuild the heap at once; the user must make them only while
// idle, as the block itself does not enforce this.
module first_fit_block_allocator #(
   parameter int NUM_SLOTS   = ffa_pkg::NUM_SLOTS_DEF,
   parameter int BLOCK_BYTES = ffa_pkg::BLOCK_BYTES_DEF,
   parameter int DESC_BYTES  = ffa_pkg::DESC_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire ffa_pkg::req_type req_payload,
   output logic                  busy,
   output logic                  rsp_valid,
   output ffa_pkg::rsp_type      rsp_payload,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int SW = $clog2(NUM_SLOTS * (DESC_BYTES + BLOCK_BYTES) + 1);

   logic [31:0]   heap_base_ff;
   logic [6:0]    block_count_ff;
   logic          cfg_wr;
   logic [IW:0]   n_active;
   ffa_pkg::slot_ctl_type ctl;
   logic [IW-1:0] look_idx;
   logic [IW-1:0] wr_idx;
   logic [SW-1:0] wr_data;
   logic          look_head;
   logic          look_free;
   logic [SW-1:0] size_q;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff   <= '0;
         block_count_ff <= 7'd64;
      end else if (cfg_wr) begin
         if (paddr[2] == ffa_pkg::REG_HEAP_BASE) heap_base_ff <= pwdata;
         else block_count_ff <= pwdata[6:0];
      end
   end

   assign prdata = (paddr[2] == ffa_pkg::REG_HEAP_BASE) ? heap_base_ff
                                                       : {25'd0, block_count_ff};

   // Active slots, clamped to one through NUM_SLOTS.
   always_comb begin
      if (block_count_ff == 7'd0) begin
         n_active = (IW + 1)'(1);
      end else if (32'(block_count_ff) > 32'(NUM_SLOTS)) begin
         n_active = (IW + 1)'(NUM_SLOTS);
      end else begin
         n_active = (IW + 1)'(block_count_ff);
      end
   end

   ffa_ctrl #(
      .NUM_SLOTS   (NUM_SLOTS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .DESC_BYTES  (DESC_BYTES),
      .IW          (IW),
      .SW          (SW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg_wr      (cfg_wr),
      .heap_base   (heap_base_ff),
      .n_active    (n_active),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .ctl         (ctl),
      .look_idx    (look_idx),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .look_head   (look_head),
      .look_free   (look_free),
      .size_q      (size_q)
   );

   ffa_slots #(
      .NUM_SLOTS   (NUM_SLOTS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .IW          (IW),
      .SW          (SW)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .look_idx  (look_idx),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .look_head (look_head),
      .look_free (look_free),
      .size_q    (size_q)
   );

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // The block goes idle exactly when it delivers a result.
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("block went idle without a result");

   // Results never come in two consecutive cycles.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in a row");

endmodule
`default_nettype wire
